>>> rtl/core/ilte_pkg.sv
// Package for the integer list table engine.
// Holds command and status codes, the decoded operation type, the queue item type and the sequencer state type.
// No dependencies.
package ilte_pkg;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_SORT   = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;
  localparam logic [2:0] CMD_DELETE = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOLIST   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR, OP_APPEND, OP_INSERT, OP_SORT, OP_SEARCH, OP_DELETE, OP_READ, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic [9:0]         ridx;
  } cmd_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_SORT_RD, S_SORT_KEY,
    S_BIN_RD, S_BIN_CMP, S_LIN_RD, S_LIN_CMP, S_FOUND, S_DEL_RD, S_DEL_WR,
    S_RD_ISSUE, S_RD_DATA
  } state_t;

endpackage

>>> rtl/core/ilte_if.sv
// Channel interfaces for the integer list table engine: command beats in, result beats out.
// No dependencies.
interface ilte_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] operand_value;
  logic [9:0]         read_index;
  modport source(output valid, cmd, operand_value, read_index, input ready);
  modport sink(input valid, cmd, operand_value, read_index, output ready);
endinterface

interface ilte_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [9:0]         found_index;
  logic signed [31:0] entry_value;
  logic [10:0]        list_length;
  logic               is_sorted;
  modport source(output valid, status, found_index, entry_value, list_length, is_sorted,
                 input ready);
  modport sink(input valid, status, found_index, entry_value, list_length, is_sorted,
               output ready);
endinterface

>>> rtl/core/integer_list_table_engine_unit.sv
// Top level of the integer list table engine.
// Depends on ilte_pkg, ilte_in_if, ilte_out_if, ilte_front and ilte_back.
//
// Commands arrive as beats on in_ch (valid/ready); each gives exactly one result beat
// on out_ch, in order. The front end queues up to two decoded commands, so input is
// taken while the back end works or while a result waits for the receiver.
// The back end runs one command at a time against a store with one write port and one
// registered read port, reading each entry that it visits. Clear, append, unsorted
// insert and failing checks finish as the back end takes the command; read fetches
// one entry; a search or delete on a sorted list is a binary search; an unsorted
// search or delete and a sorted insert visit the entries one by one; a delete then
// moves the later entries down one place; sort is an insertion sort.
// A result stays on out_ch until taken; while it waits, the back end starts no new
// command and the queue fills, after which in_ch.ready falls.
// Synchronous reset empties the queue, drops the list (no list loaded, length zero,
// unsorted) and clears any pending result; the store contents are not cleared.
module integer_list_table_engine_unit import ilte_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  ilte_in_if.sink    in_ch,
  ilte_out_if.source out_ch
);

  logic      q_valid, q_pop;
  cmd_item_t q_item;

  ilte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ilte_back #(.DEPTH(DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/core/ilte_front.sv
// Front end: accepts command beats, decodes them and holds them in a two-entry queue.
// Depends on ilte_pkg and ilte_in_if.
module ilte_front import ilte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ilte_in_if.sink   in_ch,
  output logic      q_valid,
  output cmd_item_t q_item,
  input  logic      q_pop
);

  cmd_item_t  q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_item_t  dec;
  logic       push;

  always_comb begin
    dec.value = in_ch.operand_value;
    dec.ridx  = in_ch.read_index;
    unique case (in_ch.cmd)
      CMD_CLEAR:  dec.op = OP_CLEAR;
      CMD_APPEND: dec.op = OP_APPEND;
      CMD_INSERT: dec.op = OP_INSERT;
      CMD_SORT:   dec.op = OP_SORT;
      CMD_SEARCH: dec.op = OP_SEARCH;
      CMD_DELETE: dec.op = OP_DELETE;
      CMD_READ:   dec.op = OP_READ;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/core/ilte_back.sv
// Back end: the list store and the sequencer that carries out one command at a time.
// Depends on ilte_pkg and ilte_out_if.
module ilte_back import ilte_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_item_t q_item,
  output logic      q_pop,
  ilte_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic               we;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic               loaded_r, loaded_nxt, sorted_r, sorted_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [9:0]         ridx_r, ridx_nxt;
  logic [LW-1:0]      pos_r, pos_nxt, outer_r, outer_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      mid_r, mid_nxt, hit_r, hit_nxt;
  logic               hitv_r, hitv_nxt;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [AW-1:0]      out_found_r;
  logic signed [31:0] out_entry_r;
  logic [LW-1:0]      out_len_r;
  logic               out_sorted_r;

  logic               fin;
  logic [2:0]         fin_st;
  logic [AW-1:0]      fin_found;
  logic signed [31:0] fin_entry;

  logic               out_free, full, gt, eq, sort_more, bin_more, lin_more, del_more;
  logic               hit_more, rd_range;
  logic [LW:0]        mid_sum;
  logic [AW-1:0]      mid_calc;
  logic [LW-1:0]      bin_lo_n, bin_hi_n, hit_ext;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid && out_free;
  assign full      = len_r >= LW'(DEPTH);
  assign gt        = rdata_r > key_r;
  assign eq        = rdata_r == key_r;
  assign sort_more = (outer_r + LW'(1)) < len_r;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - (LW + 1)'(1);
  assign mid_calc  = AW'(mid_sum >> 1);
  assign bin_lo_n  = (key_r > rdata_r) ? LW'(mid_r) + LW'(1) : lo_r;
  assign bin_hi_n  = (key_r > rdata_r) ? hi_r : LW'(mid_r);
  assign bin_more  = bin_lo_n < bin_hi_n;
  assign lin_more  = (idx_r + LW'(1)) < len_r;
  assign del_more  = (idx_r + LW'(2)) < len_r;
  assign hit_ext   = LW'(hit_r);
  assign hit_more  = (hit_ext + LW'(1)) < len_r;
  assign rd_range  = 32'(q_item.ridx) >= 32'(len_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_item.op != OP_CLEAR && (!loaded_r || q_item.op == OP_NOP)) begin
            state_nxt = S_IDLE;
          end else begin
            unique case (q_item.op)
              OP_INSERT: begin
                if (!full && sorted_r && len_r != '0) state_nxt = S_INS_RD;
              end
              OP_SORT: begin
                if (len_r > LW'(1)) state_nxt = S_SORT_RD;
              end
              OP_SEARCH, OP_DELETE: begin
                if (len_r != '0) state_nxt = sorted_r ? S_BIN_RD : S_LIN_RD;
              end
              OP_READ: begin
                if (!rd_range) state_nxt = S_RD_ISSUE;
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_INS_RD:  state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (gt) begin
          state_nxt = (pos_r == LW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = (op_r == OP_SORT && sort_more) ? S_SORT_RD : S_IDLE;
        end
      end
      S_INS_PUT: state_nxt = (op_r == OP_SORT && sort_more) ? S_SORT_RD : S_IDLE;
      S_SORT_RD:  state_nxt = S_SORT_KEY;
      S_SORT_KEY: state_nxt = S_INS_RD;
      S_BIN_RD:   state_nxt = S_BIN_CMP;
      S_BIN_CMP: begin
        if (eq) state_nxt = S_FOUND;
        else state_nxt = bin_more ? S_BIN_RD : S_IDLE;
      end
      S_LIN_RD:   state_nxt = S_LIN_CMP;
      S_LIN_CMP: begin
        if (eq && op_r == OP_DELETE) state_nxt = S_FOUND;
        else if (lin_more) state_nxt = S_LIN_RD;
        else state_nxt = (eq || hitv_r) ? S_FOUND : S_IDLE;
      end
      S_FOUND: begin
        state_nxt = (op_r == OP_DELETE && hit_more) ? S_DEL_RD : S_IDLE;
      end
      S_DEL_RD:   state_nxt = S_DEL_WR;
      S_DEL_WR:   state_nxt = del_more ? S_DEL_RD : S_IDLE;
      S_RD_ISSUE: state_nxt = S_RD_DATA;
      S_RD_DATA:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    len_nxt    = len_r;
    loaded_nxt = loaded_r;
    sorted_nxt = sorted_r;
    key_nxt    = key_r;
    ridx_nxt   = ridx_r;
    pos_nxt    = pos_r;
    outer_nxt  = outer_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    mid_nxt    = mid_r;
    hit_nxt    = hit_r;
    hitv_nxt   = hitv_r;
    raddr      = '0;
    waddr      = '0;
    wdata      = key_r;
    we         = 1'b0;
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_found  = '0;
    fin_entry  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          op_nxt   = q_item.op;
          key_nxt  = q_item.value;
          ridx_nxt = q_item.ridx;
          if (q_item.op == OP_CLEAR) begin
            loaded_nxt = 1'b1;
            len_nxt    = '0;
            sorted_nxt = 1'b0;
            fin        = 1'b1;
          end else if (!loaded_r) begin
            fin    = 1'b1;
            fin_st = ST_NOLIST;
          end else begin
            unique case (q_item.op)
              OP_APPEND, OP_INSERT: begin
                if (full) begin
                  fin    = 1'b1;
                  fin_st = ST_FULL;
                end else if (q_item.op == OP_INSERT && sorted_r && len_r != '0) begin
                  pos_nxt = len_r;
                end else begin
                  we      = 1'b1;
                  waddr   = AW'(len_r);
                  wdata   = q_item.value;
                  len_nxt = len_r + LW'(1);
                  if (q_item.op == OP_APPEND) sorted_nxt = 1'b0;
                  fin     = 1'b1;
                end
              end
              OP_SORT: begin
                outer_nxt = LW'(1);
                if (len_r <= LW'(1)) begin
                  sorted_nxt = 1'b1;
                  fin        = 1'b1;
                end
              end
              OP_SEARCH, OP_DELETE: begin
                lo_nxt   = '0;
                hi_nxt   = len_r;
                idx_nxt  = '0;
                hitv_nxt = 1'b0;
                if (len_r == '0) begin
                  fin    = 1'b1;
                  fin_st = ST_NOTFOUND;
                end
              end
              OP_READ: begin
                if (rd_range) begin
                  fin    = 1'b1;
                  fin_st = ST_RANGE;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      S_INS_RD: raddr = AW'(pos_r - LW'(1));
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = AW'(pos_r);
        if (gt) begin
          wdata   = rdata_r;
          pos_nxt = pos_r - LW'(1);
        end else if (op_r == OP_SORT) begin
          outer_nxt = outer_r + LW'(1);
          if (!sort_more) begin
            sorted_nxt = 1'b1;
            fin        = 1'b1;
          end
        end else begin
          len_nxt = len_r + LW'(1);
          fin     = 1'b1;
        end
      end
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = AW'(pos_r);
        if (op_r == OP_SORT) begin
          outer_nxt = outer_r + LW'(1);
          if (!sort_more) begin
            sorted_nxt = 1'b1;
            fin        = 1'b1;
          end
        end else begin
          len_nxt = len_r + LW'(1);
          fin     = 1'b1;
        end
      end
      S_SORT_RD: raddr = AW'(outer_r);
      S_SORT_KEY: begin
        key_nxt = rdata_r;
        pos_nxt = outer_r;
      end
      S_BIN_RD: begin
        raddr   = mid_calc;
        mid_nxt = mid_calc;
      end
      S_BIN_CMP: begin
        if (eq) begin
          hit_nxt = mid_r;
        end else begin
          lo_nxt = bin_lo_n;
          hi_nxt = bin_hi_n;
          if (!bin_more) begin
            fin    = 1'b1;
            fin_st = ST_NOTFOUND;
          end
        end
      end
      S_LIN_RD: raddr = AW'(idx_r);
      S_LIN_CMP: begin
        if (eq) begin
          hit_nxt  = AW'(idx_r);
          hitv_nxt = 1'b1;
        end
        idx_nxt = idx_r + LW'(1);
        if (!(eq && op_r == OP_DELETE) && !lin_more && !eq && !hitv_r) begin
          fin    = 1'b1;
          fin_st = ST_NOTFOUND;
        end
      end
      S_FOUND: begin
        idx_nxt = hit_ext;
        if (op_r == OP_SEARCH) begin
          fin       = 1'b1;
          fin_found = hit_r;
        end else if (!hit_more) begin
          len_nxt   = len_r - LW'(1);
          fin       = 1'b1;
          fin_found = hit_r;
        end
      end
      S_DEL_RD: raddr = AW'(idx_r + LW'(1));
      S_DEL_WR: begin
        we      = 1'b1;
        waddr   = AW'(idx_r);
        wdata   = rdata_r;
        idx_nxt = idx_r + LW'(1);
        if (!del_more) begin
          len_nxt   = len_r - LW'(1);
          fin       = 1'b1;
          fin_found = hit_r;
        end
      end
      S_RD_ISSUE: raddr = AW'(ridx_r);
      S_RD_DATA: begin
        fin       = 1'b1;
        fin_entry = rdata_r;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    ridx_r  <= ridx_nxt;
    pos_r   <= pos_nxt;
    outer_r <= outer_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    mid_r   <= mid_nxt;
    hit_r   <= hit_nxt;
    hitv_r  <= hitv_nxt;
    if (fin) begin
      out_status_r <= fin_st;
      out_found_r  <= fin_found;
      out_entry_r  <= fin_entry;
      out_len_r    <= len_nxt;
      out_sorted_r <= sorted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      loaded_r    <= 1'b0;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      loaded_r <= loaded_nxt;
      sorted_r <= sorted_nxt;
      if (fin) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = 10'(out_found_r);
  assign out_ch.entry_value = out_entry_r;
  assign out_ch.list_length = 11'(out_len_r);
  assign out_ch.is_sorted   = out_sorted_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(DEPTH))
    else $error("List length exceeds the store depth.");

  a_sorted_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_r |-> loaded_r)
    else $error("Sorted mark set without a loaded list.");

  a_nolist: assert property (@(posedge clk) disable iff (!rst_n)
    fin && fin_st == ST_NOLIST |-> !loaded_r)
    else $error("No-list status reported while a list is loaded.");

  a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_RD || state_r == S_INS_CMP) |-> (pos_r != '0 && pos_r <= len_r))
    else $error("Insertion position out of range.");

endmodule
